// ===== sv/quaternion_rotate_vector_defines.svh =====
// ----------------------------------------------------------------------------
// quaternion_rotate_vector_defines.svh
// Assertion macros shared by the quaternion rotation block
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ROTATE_VECTOR_DEFINES_SVH
`define QUATERNION_ROTATE_VECTOR_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define QRV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define QRV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/qrv_pkg.sv =====
// ----------------------------------------------------------------------------
// qrv_pkg
// Widths, payload types and constants of the quaternion rotation pipeline
// ----------------------------------------------------------------------------
package qrv_pkg;

    // field widths
    localparam int QUAT_W = 16;
    localparam int VEC_W  = 32;

    // 16x16 product, rotation matrix entry, split halves
    localparam int PROD_W  = 2 * QUAT_W;
    localparam int COEF_W  = PROD_W + 2;
    localparam int LO_W    = 16;
    localparam int HI_W    = COEF_W - LO_W;

    // partial products and their sums
    localparam int HIP_W   = HI_W + VEC_W;
    localparam int LOP_W   = LO_W + 1 + VEC_W;
    localparam int ASUM_W  = HIP_W + 2;
    localparam int BSUM_W  = LOP_W + 2;
    localparam int NSUM_W  = ASUM_W + 1;

    // rounding: total is shifted right by 28 = 16 (split) + 12
    localparam int FINAL_SHIFT = 28 - LO_W;
    localparam int RES_W       = NSUM_W - FINAL_SHIFT;

    typedef logic signed [VEC_W-1:0]  vec_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [HIP_W-1:0]  hi_prod_t;
    typedef logic signed [LOP_W-1:0]  lo_prod_t;
    typedef logic signed [ASUM_W-1:0] asum_t;
    typedef logic signed [BSUM_W-1:0] bsum_t;
    typedef logic signed [NSUM_W-1:0] nsum_t;
    typedef logic signed [RES_W-1:0]  res_t;

    // half-up rounding bias at bit 27
    localparam bsum_t RND_BIAS = bsum_t'(1) <<< 27;

    localparam vec_t SAT_MAX = {1'b0, {(VEC_W-1){1'b1}}};
    localparam vec_t SAT_MIN = {1'b1, {(VEC_W-1){1'b0}}};

    // saturate a wide result to the vector width
    function automatic vec_t sat_vec(input res_t r);
        vec_t o;
        o = r[VEC_W-1:0];
        if (r > res_t'(SAT_MAX))
        begin
            o = SAT_MAX;
        end
        else if (r < res_t'(SAT_MIN))
        begin
            o = SAT_MIN;
        end
        return o;
    endfunction

    // true when a wide result lies outside the vector range
    function automatic logic is_clip(input res_t r);
        return (r > res_t'(SAT_MAX)) || (r < res_t'(SAT_MIN));
    endfunction

endpackage

// ===== sv/quaternion_rotate_vector.sv =====
// ----------------------------------------------------------------------------
// quaternion_rotate_vector
// Rotates a Q16.16 vector by a Q1.14 quaternion, q * v * conj(q)
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one quaternion (quat_x..quat_w,
//   signed Q1.14) and one vector (vec_x..vec_z, signed Q16.16) per
//   transaction. Output channel out_valid/out_ready returns rot_x..rot_z
//   (signed Q16.16, rounded half up, saturated) and clipped, set when any
//   component saturated. A non-unit quaternion scales the result by |q|^2.
//   The result shows on out_valid after five register stages: products,
//   matrix, multiplies, sums, round/saturate. Throughput: one transaction
//   per cycle while out_ready is high; the multiplies stage holds 18
//   multipliers of up to 18 by 32 bits.
//   Each stage holds its own valid bit; a stage loads whenever it is empty
//   or the stage after it moves, so bubbles close up during a stall.
//   When the receiver holds out_ready low the full pipeline stops with every
//   transaction kept; in_ready stays high while any stage is empty.
//   Reset (rst_n low, asynchronous) empties all stages; no result is lost
//   or repeated across a stall.
// ----------------------------------------------------------------------------
`include "quaternion_rotate_vector_defines.svh"

module quaternion_rotate_vector
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  quat_x,
    input  logic signed [15:0]  quat_y,
    input  logic signed [15:0]  quat_z,
    input  logic signed [15:0]  quat_w,
    input  logic signed [31:0]  vec_x,
    input  logic signed [31:0]  vec_y,
    input  logic signed [31:0]  vec_z,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  rot_x,
    output logic signed [31:0]  rot_y,
    output logic signed [31:0]  rot_z,
    output logic                clipped
);

    // stage valid bits
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;

    // stage load enables, from the output back
    logic en1, en2, en3, en4, en5;

    // stage 1: quaternion products and vector
    qrv_pkg::prod_t ww_reg, xx_reg, yy_reg, zz_reg, xy_reg;
    qrv_pkg::prod_t wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    qrv_pkg::prod_t ww_next, xx_next, yy_next, zz_next, xy_next;
    qrv_pkg::prod_t wz_next, xz_next, wy_next, yz_next, wx_next;
    qrv_pkg::vec_t  v1_reg [3];

    // stage 2: rotation matrix
    qrv_pkg::coef_t coef_reg  [3][3];
    qrv_pkg::coef_t coef_next [3][3];
    qrv_pkg::vec_t  v2_reg    [3];

    // stage 3: split partial products
    qrv_pkg::hi_prod_t hi_reg  [3][3];
    qrv_pkg::hi_prod_t hi_next [3][3];
    qrv_pkg::lo_prod_t lo_reg  [3][3];
    qrv_pkg::lo_prod_t lo_next [3][3];

    // stage 4: row sums
    qrv_pkg::asum_t a_reg  [3];
    qrv_pkg::asum_t a_next [3];
    qrv_pkg::bsum_t b_reg  [3];
    qrv_pkg::bsum_t b_next [3];

    // stage 5: rounded, saturated output
    qrv_pkg::vec_t rot_reg  [3];
    qrv_pkg::vec_t rot_next [3];
    logic          clipped_reg;
    logic          clipped_next;

    // load enables: a stage moves when empty or when its successor moves
    assign en5      = !out_valid_reg || out_ready;
    assign en4      = !s4_valid_reg  || en5;
    assign en3      = !s3_valid_reg  || en4;
    assign en2      = !s2_valid_reg  || en3;
    assign en1      = !s1_valid_reg  || en2;
    assign in_ready = en1;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en5)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // stage 1 logic: the ten distinct quaternion products
    always_comb
    begin
        ww_next = qrv_pkg::prod_t'(quat_w) * qrv_pkg::prod_t'(quat_w);
        xx_next = qrv_pkg::prod_t'(quat_x) * qrv_pkg::prod_t'(quat_x);
        yy_next = qrv_pkg::prod_t'(quat_y) * qrv_pkg::prod_t'(quat_y);
        zz_next = qrv_pkg::prod_t'(quat_z) * qrv_pkg::prod_t'(quat_z);
        xy_next = qrv_pkg::prod_t'(quat_x) * qrv_pkg::prod_t'(quat_y);
        wz_next = qrv_pkg::prod_t'(quat_w) * qrv_pkg::prod_t'(quat_z);
        xz_next = qrv_pkg::prod_t'(quat_x) * qrv_pkg::prod_t'(quat_z);
        wy_next = qrv_pkg::prod_t'(quat_w) * qrv_pkg::prod_t'(quat_y);
        yz_next = qrv_pkg::prod_t'(quat_y) * qrv_pkg::prod_t'(quat_z);
        wx_next = qrv_pkg::prod_t'(quat_w) * qrv_pkg::prod_t'(quat_x);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ww_reg    <= ww_next;
            xx_reg    <= xx_next;
            yy_reg    <= yy_next;
            zz_reg    <= zz_next;
            xy_reg    <= xy_next;
            wz_reg    <= wz_next;
            xz_reg    <= xz_next;
            wy_reg    <= wy_next;
            yz_reg    <= yz_next;
            wx_reg    <= wx_next;
            v1_reg[0] <= vec_x;
            v1_reg[1] <= vec_y;
            v1_reg[2] <= vec_z;
        end
    end

    // stage 2 logic: rotation matrix entries, exact
    always_comb
    begin
        coef_next[0][0] = qrv_pkg::coef_t'(ww_reg) + qrv_pkg::coef_t'(xx_reg)
                        - qrv_pkg::coef_t'(yy_reg) - qrv_pkg::coef_t'(zz_reg);
        coef_next[0][1] = (qrv_pkg::coef_t'(xy_reg) - qrv_pkg::coef_t'(wz_reg)) <<< 1;
        coef_next[0][2] = (qrv_pkg::coef_t'(xz_reg) + qrv_pkg::coef_t'(wy_reg)) <<< 1;

        coef_next[1][0] = (qrv_pkg::coef_t'(xy_reg) + qrv_pkg::coef_t'(wz_reg)) <<< 1;
        coef_next[1][1] = qrv_pkg::coef_t'(ww_reg) - qrv_pkg::coef_t'(xx_reg)
                        + qrv_pkg::coef_t'(yy_reg) - qrv_pkg::coef_t'(zz_reg);
        coef_next[1][2] = (qrv_pkg::coef_t'(yz_reg) - qrv_pkg::coef_t'(wx_reg)) <<< 1;

        coef_next[2][0] = (qrv_pkg::coef_t'(xz_reg) - qrv_pkg::coef_t'(wy_reg)) <<< 1;
        coef_next[2][1] = (qrv_pkg::coef_t'(yz_reg) + qrv_pkg::coef_t'(wx_reg)) <<< 1;
        coef_next[2][2] = qrv_pkg::coef_t'(ww_reg) - qrv_pkg::coef_t'(xx_reg)
                        - qrv_pkg::coef_t'(yy_reg) + qrv_pkg::coef_t'(zz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            coef_reg <= coef_next;
            v2_reg   <= v1_reg;
        end
    end

    // stage 3 logic: each entry split into signed high and unsigned low part
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                hi_next[i][j] =
                    qrv_pkg::hi_prod_t'($signed(coef_reg[i][j][qrv_pkg::COEF_W-1:qrv_pkg::LO_W]))
                    * qrv_pkg::hi_prod_t'(v2_reg[j]);
                lo_next[i][j] =
                    qrv_pkg::lo_prod_t'($signed({1'b0, coef_reg[i][j][qrv_pkg::LO_W-1:0]}))
                    * qrv_pkg::lo_prod_t'(v2_reg[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    // stage 4 logic: row sums, rounding bias on the low half
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_next[i] = qrv_pkg::asum_t'(hi_reg[i][0]) + qrv_pkg::asum_t'(hi_reg[i][1])
                      + qrv_pkg::asum_t'(hi_reg[i][2]);
            b_next[i] = qrv_pkg::bsum_t'(lo_reg[i][0]) + qrv_pkg::bsum_t'(lo_reg[i][1])
                      + qrv_pkg::bsum_t'(lo_reg[i][2]) + qrv_pkg::RND_BIAS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    // stage 5 logic: merge halves, drop fraction bits, saturate
    always_comb
    begin
        qrv_pkg::nsum_t n;
        qrv_pkg::res_t  r;
        clipped_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            n = qrv_pkg::nsum_t'(a_reg[i])
              + qrv_pkg::nsum_t'(b_reg[i] >>> qrv_pkg::LO_W);
            r = $signed(n[qrv_pkg::NSUM_W-1:qrv_pkg::FINAL_SHIFT]);
            rot_next[i]  = qrv_pkg::sat_vec(r);
            clipped_next = clipped_next | qrv_pkg::is_clip(r);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            rot_reg     <= rot_next;
            clipped_reg <= clipped_next;
        end
    end

    // outputs
    assign out_valid = out_valid_reg;
    assign rot_x     = rot_reg[0];
    assign rot_y     = rot_reg[1];
    assign rot_z     = rot_reg[2];
    assign clipped   = clipped_reg;

    // assertions
    `QRV_ASSERT_SAME(a_ready_when_drained, !out_valid_reg, in_ready,
        "input stalled while output stage is empty")
    `QRV_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, s1_valid_reg,
        "accepted transaction did not reach stage 1")
    `QRV_ASSERT_NEXT(a_s4_holds, s4_valid_reg && !en4,
        s4_valid_reg && $stable(a_reg[0]) && $stable(b_reg[0]),
        "stalled stage 4 lost or changed its data")
    `QRV_ASSERT_SAME(a_clip_saturates, out_valid_reg && clipped_reg,
        rot_reg[0] == qrv_pkg::SAT_MAX || rot_reg[0] == qrv_pkg::SAT_MIN ||
        rot_reg[1] == qrv_pkg::SAT_MAX || rot_reg[1] == qrv_pkg::SAT_MIN ||
        rot_reg[2] == qrv_pkg::SAT_MAX || rot_reg[2] == qrv_pkg::SAT_MIN,
        "clipped set without a saturated component")

endmodule
